### rtl/core/drek_pkg.sv
package drek_pkg;

   localparam int SAMPLE_WIDTH = 8;
   localparam int KEY_WIDTH    = 5;
   localparam int STEP_WIDTH   = 5;
   localparam int COUNT_WIDTH  = 16;

   // Largest step size that keeps delta coding alive.
   localparam logic [SAMPLE_WIDTH-1:0] STEP_LIMIT = 8'd26;

   // Range ladder thresholds on the larger maximum step.
   localparam logic [STEP_WIDTH-1:0] STEP_FLAT_MAX  = 5'd1;
   localparam logic [STEP_WIDTH-1:0] STEP_SMALL_MAX = 5'd5;
   localparam logic [STEP_WIDTH-1:0] STEP_R6_MAX    = 5'd6;
   localparam logic [STEP_WIDTH-1:0] STEP_R10_MAX   = 5'd10;
   localparam logic [STEP_WIDTH-1:0] STEP_R12_MAX   = 5'd12;
   localparam logic [STEP_WIDTH-1:0] STEP_R20_MAX   = 5'd20;

   // Encode keys.
   localparam logic [KEY_WIDTH-1:0] KEY_REJECT = 5'd0;
   localparam logic [KEY_WIDTH-1:0] KEY_FLAT   = 5'd1;
   localparam logic [KEY_WIDTH-1:0] KEY_R6     = 5'd10;
   localparam logic [KEY_WIDTH-1:0] KEY_R10    = 5'd12;
   localparam logic [KEY_WIDTH-1:0] KEY_R12    = 5'd14;
   localparam logic [KEY_WIDTH-1:0] KEY_R20    = 5'd16;
   localparam logic [KEY_WIDTH-1:0] KEY_R26    = 5'd18;
   localparam logic [KEY_WIDTH-1:0] KEY_MAX    = KEY_R26;

   typedef struct packed {
      logic [SAMPLE_WIDTH-1:0] prev;
      logic                    have_prev;
      logic [STEP_WIDTH-1:0]   max_rise;
      logic [STEP_WIDTH-1:0]   max_fall;
      logic [COUNT_WIDTH-1:0]  cnt_rise;
      logic [COUNT_WIDTH-1:0]  cnt_fall;
      logic                    rejected;
   } drek_stat_type;

   // Map buffer statistics onto the range ladder.
   function automatic logic [KEY_WIDTH-1:0] pick_key(input drek_stat_type st);
      logic [STEP_WIDTH-1:0] m;
      logic                  odd;
      logic [KEY_WIDTH-1:0]  key;
      m   = (st.max_rise >= st.max_fall) ? st.max_rise : st.max_fall;
      odd = (st.cnt_fall > st.cnt_rise);
      if (st.rejected) begin
         key = KEY_REJECT;
      end else if (m <= STEP_FLAT_MAX) begin
         key = KEY_FLAT;
      end else if (m <= STEP_SMALL_MAX) begin
         key = {m[3:0] - 4'd1, odd};
      end else if (m <= STEP_R6_MAX) begin
         key = KEY_R6 | {4'd0, odd};
      end else if (m <= STEP_R10_MAX) begin
         key = KEY_R10 | {4'd0, odd};
      end else if (m <= STEP_R12_MAX) begin
         key = KEY_R12 | {4'd0, odd};
      end else if (m <= STEP_R20_MAX) begin
         key = KEY_R20 | {4'd0, odd};
      end else begin
         key = KEY_R26;
      end
      return key;
   endfunction

endpackage

### rtl/core/delta_range_encode_key_selector_unit.sv
// Delta range encode key selector.
//
// req channel: one bucket byte per word (req_sample) with req_last on the
// final byte of a buffer. A word is taken at an edge where req_valid is high
// and req_stall is low. Bytes may arrive in every cycle.
// rsp channel: one word per buffer, rsp_encode_key in 0..18, 0 when some
// step between neighboring bytes exceeded 26.
//
// A final byte goes from the input register through the step/update stage
// into the result register. Throughput: one byte per cycle unless a final
// byte waits on a stalled result, set by the single step/update stage.
//
// Reset (synchronous, active high) drops both pipeline valids and clears the
// buffer statistics, so the first byte after reset starts a new buffer.
//
// When the receiver stalls, the result register holds. Non-final bytes keep
// flowing; only a final byte waits in the input register until the pending
// key is taken, and req_stall rises for that time.
module delta_range_encode_key_selector_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [drek_pkg::SAMPLE_WIDTH-1:0] req_sample,
   input  logic                              req_last,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [drek_pkg::KEY_WIDTH-1:0]    rsp_encode_key
);
   import drek_pkg::*;

   // Input register.
   logic                    in_valid_ff;
   logic [SAMPLE_WIDTH-1:0] in_sample_ff;
   logic                    in_last_ff;

   // Running statistics of the current buffer.
   drek_stat_type           stat_ff;
   drek_stat_type           stat_in;

   // Result register.
   logic                    rsp_valid_ff;
   logic [KEY_WIDTH-1:0]    rsp_key_ff;
   logic [KEY_WIDTH-1:0]    key_in;

   logic                    advance;
   logic                    fire;

   drek_step u_step (
      .stat      (stat_ff),
      .sample    (in_sample_ff),
      .stat_next (stat_in),
      .key       (key_in)
   );

   // A final byte may only advance when the result register is free or
   // being emptied this cycle.
   assign advance   = !(in_last_ff && rsp_valid_ff && rsp_stall);
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         stat_ff      <= '0;
      end else begin
         if (!req_stall) in_valid_ff <= req_valid;
         // Advance statistics; drop them at the end of a buffer.
         if (fire) stat_ff <= in_last_ff ? '0 : stat_in;
         if (fire && in_last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers: hold while stalled.
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_sample_ff <= req_sample;
         in_last_ff   <= req_last;
      end
      if (fire && in_last_ff) rsp_key_ff <= key_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_encode_key = rsp_key_ff;

endmodule

### rtl/core/drek_step.sv
module drek_step (
   input  drek_pkg::drek_stat_type               stat,
   input  logic [drek_pkg::SAMPLE_WIDTH-1:0]     sample,
   output drek_pkg::drek_stat_type               stat_next,
   output logic [drek_pkg::KEY_WIDTH-1:0]        key
);
   import drek_pkg::*;

   logic                    rise;
   logic [SAMPLE_WIDTH-1:0] diff;
   logic                    over;
   logic                    active;
   logic [STEP_WIDTH-1:0]   step;

   assign rise   = (sample >= stat.prev);
   assign diff   = rise ? (sample - stat.prev) : (stat.prev - sample);
   assign over   = (diff > STEP_LIMIT);
   assign active = stat.have_prev && !stat.rejected;
   assign step   = diff[STEP_WIDTH-1:0];

   always_comb begin
      stat_next           = stat;
      stat_next.prev      = sample;
      stat_next.have_prev = 1'b1;
      if (active) begin
         if (over) begin
            stat_next.rejected = 1'b1;
         end else if (rise) begin
            if (step > stat.max_rise) stat_next.max_rise = step;
            if ((diff == 8'd1) && (stat.cnt_rise != '1)) begin
               stat_next.cnt_rise = stat.cnt_rise + 1'b1;
            end
         end else begin
            if (step > stat.max_fall) stat_next.max_fall = step;
            if ((diff == 8'd1) && (stat.cnt_fall != '1)) begin
               stat_next.cnt_fall = stat.cnt_fall + 1'b1;
            end
         end
      end
   end

   assign key = pick_key(stat_next);

endmodule

### rtl/core/drek_checker.sv
module drek_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              req_last,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [drek_pkg::KEY_WIDTH-1:0]    rsp_encode_key
);
   import drek_pkg::*;

   logic req_take_last;
   assign req_take_last = req_valid && !req_stall && req_last;

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_encode_key))
      else $error("stalled result word changed");

   // Keys stay on the ladder.
   a_key_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_encode_key <= KEY_MAX)
      else $error("encode key out of range");

   // A fresh result follows a final byte taken on the request channel.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_take_last, 2))
      else $error("result word without a final byte");

   // Reset leaves both channels empty and open.
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("channels busy after reset");

endmodule

bind delta_range_encode_key_selector_unit drek_checker u_drek_checker (.*);
